### hw/rtl/jkve_pkg.sv
// Shared types, constants and helper functions of the JSON key/value extractor.
package jkve_pkg;

	localparam int MAX_KEY_BYTES = 16;
	// The match window holds the key plus its two enclosing quotes.
	localparam int WIN_DEPTH     = MAX_KEY_BYTES + 2;
	localparam int HIST_DEPTH    = WIN_DEPTH - 1;
	localparam int KEY_LEN_W     = 5;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 64;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_KEY_LOW  = 2'd0,
		CFG_KEY_HIGH = 2'd1,
		CFG_KEY_LEN  = 2'd2,
		CFG_MODE     = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		MODE_QUOTED  = 2'd0,
		MODE_ESCAPED = 2'd1,
		MODE_RAW     = 2'd2
	} value_mode_t;

	typedef enum logic [2:0] {
		PH_KEY   = 3'd0,
		PH_COLON = 3'd1,
		PH_OPEN  = 3'd2,
		PH_VALUE = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] key_bytes_low;
		logic [CFG_DATA_W-1:0] key_bytes_high;
		logic [KEY_LEN_W-1:0]  key_length;
		logic [1:0]            value_mode;
	} cfg_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       found;
		logic       last;
	} result_t;

	// Mode code 3 behaves as the raw mode.
	function automatic value_mode_t mode_norm(input logic [1:0] m);
		value_mode_t r;
		if (m == 2'd3) begin
			r = MODE_RAW;
		end else begin
			r = value_mode_t'(m);
		end
		return r;
	endfunction

endpackage

### hw/rtl/jkve_channels.sv
// Handshake channel interfaces: document input, result output and configuration writes.
interface jkve_doc_if;
	import jkve_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] doc_byte;
	logic       doc_end;
	modport source (output valid, output doc_byte, output doc_end, input ready);
	modport sink   (input valid, input doc_byte, input doc_end, output ready);
endinterface

interface jkve_result_if;
	import jkve_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] value_byte;
	logic       found;
	logic       last;
	modport source (output valid, output value_byte, output found, output last, input ready);
	modport sink   (input valid, input value_byte, input found, input last, output ready);
endinterface

interface jkve_cfg_if;
	import jkve_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/jkve_cfg_regs.sv
// Configuration register file written through the configuration channel.
module jkve_cfg_regs
	import jkve_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	jkve_cfg_if.sink   cfg,
	output cfg_t       cfg_regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_regs  = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_index_t'(cfg.index))
				CFG_KEY_LOW:  regs_q.key_bytes_low  <= cfg.data;
				CFG_KEY_HIGH: regs_q.key_bytes_high <= cfg.data;
				CFG_KEY_LEN:  regs_q.key_length     <= cfg.data[KEY_LEN_W-1:0];
				CFG_MODE:     regs_q.value_mode     <= cfg.data[1:0];
				default:      regs_q <= regs_q;
			endcase
		end
	end

endmodule

### hw/rtl/jkve_key_match.sv
// Parallel compare of the byte window against the quoted key for every key length.
module jkve_key_match
	import jkve_pkg::*;
(
	input  cfg_t       cfg_regs,
	input  logic [7:0] win [WIN_DEPTH],
	output logic       match
);

	logic [2*CFG_DATA_W-1:0] key_all;
	logic [KEY_LEN_W-1:0]    len_eff;
	logic [MAX_KEY_BYTES:0]  cand;

	assign key_all = {cfg_regs.key_bytes_high, cfg_regs.key_bytes_low};
	assign len_eff = (cfg_regs.key_length > KEY_LEN_W'(MAX_KEY_BYTES)) ?
		KEY_LEN_W'(MAX_KEY_BYTES) : cfg_regs.key_length;

	// The window is newest first, so key byte i sits at window position len-i.
	always_comb begin
		for (int l = 0; l <= MAX_KEY_BYTES; l++) begin
			cand[l] = (win[0] == CH_QUOTE) && (win[l+1] == CH_QUOTE);
			for (int i = 0; i < MAX_KEY_BYTES; i++) begin
				if (i < l) begin
					cand[l] = cand[l] && (win[l-i] == key_all[8*i +: 8]);
				end
			end
		end
	end

	assign match = cand[len_eff];

endmodule

### hw/rtl/jkve_parser.sv
// Per-document parse state: key search, colon and opening search, value emission.
module jkve_parser
	import jkve_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	input  cfg_t       cfg_regs,
	output logic       res_valid,
	output result_t    res
);

	phase_t     phase_q, phase_d;
	logic [7:0] recent_q [HIST_DEPTH];
	logic [7:0] recent_d [HIST_DEPTH];
	logic [7:0] win [WIN_DEPTH];
	logic [1:0] bip_q, bip_d;
	logic [7:0] held0_q, held0_d;
	logic [7:0] held1_q, held1_d;
	logic [1:0] hc_q, hc_d;
	logic       key_hit;
	value_mode_t mode;

	assign mode = mode_norm(cfg_regs.value_mode);

	always_comb begin
		win[0] = in_byte;
		for (int k = 1; k < WIN_DEPTH; k++) begin
			win[k] = recent_q[k-1];
		end
	end

	jkve_key_match u_key_match (
		.cfg_regs (cfg_regs),
		.win      (win),
		.match    (key_hit)
	);

	always_comb begin
		logic [1:0] bip_inc;
		logic       have;
		logic [7:0] ob;

		phase_d = phase_q;
		bip_d   = bip_q;
		held0_d = held0_q;
		held1_d = held1_q;
		hc_d    = hc_q;
		have    = 1'b0;
		ob      = 8'h00;
		bip_inc = (bip_q == 2'd3) ? 2'd3 : bip_q + 2'd1;
		for (int k = 0; k < HIST_DEPTH; k++) begin
			recent_d[k] = win[k];
		end

		unique case (phase_q)
			PH_KEY: begin
				if (key_hit) begin
					phase_d = PH_COLON;
				end
			end
			PH_COLON: begin
				if (in_byte == CH_COLON) begin
					phase_d = (mode == MODE_RAW) ? PH_VALUE : PH_OPEN;
					bip_d   = 2'd0;
					hc_d    = 2'd0;
				end
			end
			PH_OPEN: begin
				bip_d = bip_inc;
				if (mode == MODE_QUOTED) begin
					if (in_byte == CH_QUOTE) begin
						phase_d = PH_VALUE;
					end
				end else if (bip_inc == 2'd3 && recent_q[1] == CH_QUOTE &&
						recent_q[0] == CH_BSLASH && in_byte == CH_QUOTE) begin
					phase_d = PH_VALUE;
					hc_d    = 2'd0;
				end
			end
			PH_VALUE: begin
				unique case (mode)
					MODE_QUOTED: begin
						if (in_byte == CH_QUOTE) begin
							phase_d = PH_DONE;
						end else begin
							have = 1'b1;
							ob   = in_byte;
						end
					end
					MODE_RAW: begin
						if (in_byte == CH_COMMA) begin
							phase_d = PH_DONE;
						end else begin
							have = 1'b1;
							ob   = in_byte;
						end
					end
					MODE_ESCAPED: begin
						// Two bytes lag behind so a closing backslash-quote-quote is never sent.
						if (hc_q == 2'd2 && held0_q == CH_BSLASH && held1_q == CH_QUOTE &&
								in_byte == CH_QUOTE) begin
							phase_d = PH_DONE;
							hc_d    = 2'd0;
						end else if (hc_q == 2'd2) begin
							have    = 1'b1;
							ob      = held0_q;
							held0_d = held1_q;
							held1_d = in_byte;
						end else if (hc_q == 2'd0) begin
							held0_d = in_byte;
							hc_d    = 2'd1;
						end else begin
							held1_d = in_byte;
							hc_d    = 2'd2;
						end
					end
					default: phase_d = phase_q;
				endcase
			end
			PH_DONE: phase_d = phase_q;
			default: phase_d = phase_q;
		endcase

		res_valid      = in_end || have;
		res.value_byte = in_end ? 8'h00 : ob;
		res.found      = in_end && (phase_d == PH_DONE);
		res.last       = in_end;

		if (in_end) begin
			phase_d = PH_KEY;
			bip_d   = 2'd0;
			held0_d = 8'h00;
			held1_d = 8'h00;
			hc_d    = 2'd0;
			for (int k = 0; k < HIST_DEPTH; k++) begin
				recent_d[k] = 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			bip_q   <= 2'd0;
			held0_q <= 8'h00;
			held1_q <= 8'h00;
			hc_q    <= 2'd0;
			for (int k = 0; k < HIST_DEPTH; k++) begin
				recent_q[k] <= 8'h00;
			end
		end else if (step) begin
			phase_q <= phase_d;
			bip_q   <= bip_d;
			held0_q <= held0_d;
			held1_q <= held1_d;
			hc_q    <= hc_d;
			for (int k = 0; k < HIST_DEPTH; k++) begin
				recent_q[k] <= recent_d[k];
			end
		end
	end

endmodule

### hw/rtl/json_key_value_extractor.sv
// Top level of the JSON key/value extractor: input register, parser and result register.
//
//   channel  direction  beat contents
//   doc      in         doc_byte, doc_end
//   result   out        value_byte, found, last
//   cfg      in         index, data (always ready)
//
// One document byte is taken per cycle while the result register is free. Each byte passes
// the input register, then its result beat enters the result register with the state update.
// A byte yields zero or one result beat; the final byte of a document yields the end beat.
// A stalled result register holds the input register, and the doc channel keeps
// accepting as long as the input register can move on the same edge.
// Reset clears the parse state and all configuration registers to zero.
module json_key_value_extractor
	import jkve_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	jkve_doc_if.sink      doc,
	jkve_result_if.source result,
	jkve_cfg_if.sink      cfg
);

	cfg_t       cfg_regs;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       out_free;
	logic       step;
	logic       p_valid;
	result_t    p_res;
	logic       res_valid_q;
	result_t    res_q;

	jkve_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	assign out_free  = !res_valid_q || result.ready;
	assign step      = valid_s1 && out_free;
	assign doc.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (doc.ready) begin
			valid_s1 <= doc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (doc.valid && doc.ready) begin
			byte_s1 <= doc.doc_byte;
			end_s1  <= doc.doc_end;
		end
	end

	jkve_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_byte   (byte_s1),
		.in_end    (end_s1),
		.cfg_regs  (cfg_regs),
		.res_valid (p_valid),
		.res       (p_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= step && p_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && p_valid) begin
			res_q <= p_res;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.value_byte = res_q.value_byte;
	assign result.found      = res_q.found;
	assign result.last       = res_q.last;

endmodule
